// ----- hw/rtl/pmfb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmfb_pkg: shared types and constants of the paged framebuffer engine
// Display geometry, store addressing, refresh command bytes, controller
// states and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pmfb_pkg;

  // Display geometry
  localparam int COLUMNS     = 128;
  localparam int PAGES       = 16;
  localparam int ROWS        = PAGES * 8;
  localparam int STORE_DEPTH = PAGES * COLUMNS;

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int SLOT_W = $clog2(COLUMNS + 3);

  // Refresh stream slots within one page
  localparam int SLOT_PAGE_CMD = 0;
  localparam int SLOT_COL_LO   = 1;
  localparam int SLOT_COL_HI   = 2;
  localparam int SLOT_DATA0    = 3;
  localparam int SLOT_LAST     = COLUMNS + 2;

  // Command bytes
  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LO    = 8'h00;
  localparam logic [7:0] CMD_COL_HI    = 8'h10;

  typedef enum logic [1:0] {
    REQ_PIXEL   = 2'd0,
    REQ_SQUARE  = 2'd1,
    REQ_CLEAR   = 2'd2,
    REQ_REFRESH = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK_RD,
    S_WALK_WR,
    S_REF_RD,
    S_REF_EMIT
  } state_t;

  typedef struct packed {
    logic load_req;
    logic clr_start;
    logic clr_step;
    logic walk_rd;
    logic walk_wr;
    logic ref_rd;
    logic ref_emit;
  } dp_cmd_t;

  typedef struct packed {
    logic walk_ok;
    logic walk_last;
    logic clr_last;
    logic ref_is_data;
    logic out_free;
  } dp_status_t;

  // Store byte address of (page, column)
  function automatic logic [ADDR_W-1:0] store_addr(input logic [PAGE_W-1:0] page,
                                                   input logic [COL_W-1:0]  col);
    store_addr = ADDR_W'(int'(page) * COLUMNS + int'(col));
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/pmfb_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmfb_ctrl: request sequencer
// Accepts one request at a time and steps the datapath through the store
// clearing sweep, the read-modify-write walk and the refresh byte emission.
// ----------------------------------------------------------------------------
module pmfb_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   req_valid,
  output logic                        req_stall,
  input  wire logic [1:0]             req_type,
  input  wire pmfb_pkg::dp_status_t   sts,
  output pmfb_pkg::dp_cmd_t           cmd
);
  import pmfb_pkg::*;

  state_t state, state_next;
  logic   accept;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && (state == S_IDLE);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          case (req_type_t'(req_type))
            REQ_PIXEL, REQ_SQUARE: state_next = sts.walk_ok ? S_WALK_RD : S_IDLE;
            REQ_CLEAR:             state_next = S_CLEAR;
            REQ_REFRESH:           state_next = sts.ref_is_data ? S_REF_RD : S_REF_EMIT;
            default:               state_next = S_IDLE;
          endcase
        end
      end
      S_WALK_RD:  state_next = S_WALK_WR;
      S_WALK_WR:  state_next = sts.walk_last ? S_IDLE : S_WALK_RD;
      S_REF_RD:   state_next = S_REF_EMIT;
      S_REF_EMIT: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd = '0;
    case (state)
      S_CLEAR: cmd.clr_step = 1'b1;
      S_IDLE: begin
        cmd.load_req  = accept;
        cmd.clr_start = accept && (req_type_t'(req_type) == REQ_CLEAR);
      end
      S_WALK_RD:  cmd.walk_rd = 1'b1;
      S_WALK_WR:  cmd.walk_wr = 1'b1;
      S_REF_RD:   cmd.ref_rd = 1'b1;
      S_REF_EMIT: cmd.ref_emit = sts.out_free;
      default:    cmd = '0;
    endcase
  end

  // Each store write of the walk follows the read of the same byte
  assert property (@(posedge clk) disable iff (rst)
    cmd.walk_wr |-> $past(cmd.walk_rd))
    else $error("walk write without preceding read");

  // Never load the result register while it still holds an untaken byte
  assert property (@(posedge clk) disable iff (rst)
    cmd.ref_emit |-> sts.out_free)
    else $error("result emitted over a held result");

  // Leave the clearing sweep only after its last entry
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && $past(state) == S_CLEAR) |-> $past(sts.clr_last))
    else $error("clearing sweep ended early");

endmodule
`default_nettype wire

// ----- hw/rtl/pmfb_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmfb_datapath: frame store, walk counters, refresh position, result register
// Holds the page-organized byte store, the column/page walk used by pixel and
// square requests, the clearing sweep counter and the refresh stream position.
// ----------------------------------------------------------------------------
module pmfb_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [1:0]           req_type,
  input  wire logic [7:0]           x,
  input  wire logic [7:0]           y,
  input  wire logic [7:0]           square_size,
  input  wire logic                 pixel_on,
  input  wire pmfb_pkg::dp_cmd_t    cmd,
  output pmfb_pkg::dp_status_t      sts,
  output logic                      res_valid,
  input  wire logic                 res_stall,
  output logic [7:0]                out_byte,
  output logic                      is_command,
  output logic                      frame_last
);
  import pmfb_pkg::*;

  // Frame store
  logic [7:0]        store [STORE_DEPTH];
  logic [7:0]        rd_data;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata;

  // Clearing sweep
  logic [ADDR_W-1:0] clear_addr;

  // Walk registers
  logic [COL_W-1:0]  cur_col, last_col;
  logic [PAGE_W-1:0] cur_page, first_page, last_page;
  logic [2:0]        lo_bit, hi_bit;
  logic              set_on;

  // Refresh position
  logic [PAGE_W-1:0] ref_page;
  logic [SLOT_W-1:0] ref_slot;

  // Request decode for the walk bounds
  logic [8:0]        span, x_end, y_end, x_end_c, y_end_c, last_row9;
  logic              in_range;
  logic [2:0]        lo_eff, hi_eff;
  logic [7:0]        mask, walk_byte;
  logic [ADDR_W-1:0] walk_addr, ref_addr;
  logic [7:0]        emit_byte;
  logic              emit_data, emit_last;

  // Pixel is a one-by-one walk; a square always sets
  always_comb begin
    span      = (req_type_t'(req_type) == REQ_PIXEL) ? 9'd1 : {1'b0, square_size};
    x_end     = {1'b0, x} + span;
    y_end     = {1'b0, y} + span;
    x_end_c   = (x_end > 9'(COLUMNS)) ? 9'(COLUMNS) : x_end;
    y_end_c   = (y_end > 9'(ROWS)) ? 9'(ROWS) : y_end;
    last_row9 = y_end_c - 9'd1;
    in_range  = ({1'b0, x} < 9'(COLUMNS)) && ({1'b0, y} < 9'(ROWS)) && (span != 9'd0);
  end

  // Latch walk bounds and step through columns, pages within each column
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      cur_col    <= COL_W'(x);
      last_col   <= COL_W'(x_end_c - 9'd1);
      cur_page   <= PAGE_W'(y >> 3);
      first_page <= PAGE_W'(y >> 3);
      last_page  <= PAGE_W'(last_row9 >> 3);
      lo_bit     <= y[2:0];
      hi_bit     <= last_row9[2:0];
      set_on     <= (req_type_t'(req_type) == REQ_PIXEL) ? pixel_on : 1'b1;
    end else if (cmd.walk_wr) begin
      if (cur_page == last_page) begin
        cur_page <= first_page;
        cur_col  <= cur_col + COL_W'(1);
      end else begin
        cur_page <= cur_page + PAGE_W'(1);
      end
    end
  end

  // Bit mask of the rows covered in the current byte
  always_comb begin
    lo_eff    = (cur_page == first_page) ? lo_bit : 3'd0;
    hi_eff    = (cur_page == last_page) ? hi_bit : 3'd7;
    mask      = (8'hFF << lo_eff) & (8'hFF >> (3'd7 - hi_eff));
    walk_byte = set_on ? (rd_data | mask) : (rd_data & ~mask);
    walk_addr = store_addr(cur_page, cur_col);
    ref_addr  = store_addr(ref_page, COL_W'(ref_slot - SLOT_W'(SLOT_DATA0)));
  end

  // Clearing sweep counter
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_start) begin
      clear_addr <= '0;
    end else if (cmd.clr_step) begin
      clear_addr <= clear_addr + ADDR_W'(1);
    end
  end

  // Store ports
  assign mem_we    = cmd.clr_step || cmd.walk_wr;
  assign mem_waddr = cmd.clr_step ? clear_addr : walk_addr;
  assign mem_wdata = cmd.clr_step ? 8'h00 : walk_byte;
  assign mem_re    = cmd.walk_rd || cmd.ref_rd;
  assign mem_raddr = cmd.ref_rd ? ref_addr : walk_addr;

  always_ff @(posedge clk) begin
    if (mem_we) store[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data <= store[mem_raddr];
  end

  // Select the refresh byte for the current slot
  always_comb begin
    emit_data = 1'b0;
    if (ref_slot == SLOT_W'(SLOT_PAGE_CMD)) begin
      emit_byte = CMD_PAGE_BASE | 8'(ref_page);
    end else if (ref_slot == SLOT_W'(SLOT_COL_LO)) begin
      emit_byte = CMD_COL_LO;
    end else if (ref_slot == SLOT_W'(SLOT_COL_HI)) begin
      emit_byte = CMD_COL_HI;
    end else begin
      emit_byte = rd_data;
      emit_data = 1'b1;
    end
    emit_last = emit_data && (ref_page == PAGE_W'(PAGES - 1)) &&
                (ref_slot == SLOT_W'(SLOT_LAST));
  end

  // Advance the refresh position, wrap after the last page
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_page <= '0;
      ref_slot <= '0;
    end else if (cmd.ref_emit) begin
      if (ref_slot == SLOT_W'(SLOT_LAST)) begin
        ref_slot <= '0;
        ref_page <= (ref_page == PAGE_W'(PAGES - 1)) ? '0 : ref_page + PAGE_W'(1);
      end else begin
        ref_slot <= ref_slot + SLOT_W'(1);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.ref_emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ref_emit) begin
      out_byte   <= emit_byte;
      is_command <= !emit_data;
      frame_last <= emit_last;
    end
  end

  // Status to the controller
  always_comb begin
    sts.walk_ok     = in_range;
    sts.walk_last   = (cur_col == last_col) && (cur_page == last_page);
    sts.clr_last    = (clear_addr == ADDR_W'(STORE_DEPTH - 1));
    sts.ref_is_data = (ref_slot >= SLOT_W'(SLOT_DATA0));
    sts.out_free    = !res_valid || !res_stall;
  end

  // The frame end mark only rides on a data byte
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && frame_last) |-> !is_command)
    else $error("frame end marked on a command byte");

endmodule
`default_nettype wire

// ----- hw/rtl/paged_mono_framebuffer_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// paged_mono_framebuffer_engine: page-mode monochrome framebuffer
// Request channel (req_valid/req_stall) carries pixel writes, square fills,
// store clears and refresh ticks; the result channel (res_valid/res_stall)
// carries one refresh stream byte per refresh tick, flagged command or data.
// A request is taken only while the sequencer is idle; one request at a time.
// Store work per request:
//   pixel write in range: one store read, then one store write
//   square fill: read+write per byte covered (column by column, page by page)
//   out-of-range pixel or square, zero-size square: no store access
//   clear: all 2048 store bytes (one store byte zeroed per cycle)
//   refresh tick: a data byte takes a store read first, a command byte none
// An accepted tick loads the result register in the emit state; a data byte
// reaches that state through the store read state.
// After reset the block sweeps zeros through all 2048 store bytes and holds
// req_stall high until that sweep ends; the refresh position starts at page 0.
// A stalled result sits in the output register; requests are still taken, but
// a refresh tick then waits, req_stall high, until that register is free.
// ----------------------------------------------------------------------------
module paged_mono_framebuffer_engine (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_stall,
  input  wire logic [1:0] req_type,
  input  wire logic [7:0] x,
  input  wire logic [7:0] y,
  input  wire logic [7:0] square_size,
  input  wire logic       pixel_on,
  output logic            res_valid,
  input  wire logic       res_stall,
  output logic [7:0]      out_byte,
  output logic            is_command,
  output logic            frame_last
);
  import pmfb_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t sts;

  pmfb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_type  (req_type),
    .sts       (sts),
    .cmd       (cmd)
  );

  pmfb_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .req_type    (req_type),
    .x           (x),
    .y           (y),
    .square_size (square_size),
    .pixel_on    (pixel_on),
    .cmd         (cmd),
    .sts         (sts),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .out_byte    (out_byte),
    .is_command  (is_command),
    .frame_last  (frame_last)
  );

endmodule
`default_nettype wire
